// ===== design/dtmf_tone_synthesizer_assert.svh =====
// Assertion macros for the DTMF tone synthesizer checker.
// Needs signals clk and rst_n in the scope where a macro is used.
`ifndef DTMF_TONE_SYNTHESIZER_ASSERT_SVH
`define DTMF_TONE_SYNTHESIZER_ASSERT_SVH

// Same-cycle implication.
`define DTS_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DTS_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/dts_pkg.sv =====
// Package for the DTMF tone synthesizer: request codes, step and sine tables, key decode.
// No dependencies.
package dts_pkg;

    localparam logic [1:0] ACT_START  = 2'd0;
    localparam logic [1:0] ACT_SAMPLE = 2'd1;
    localparam logic [1:0] ACT_MS     = 2'd2;

    localparam int SINE_DEPTH = 128;
    localparam int SINE_W     = 7;
    localparam int SINE_AW    = $clog2(SINE_DEPTH);
    localparam int STEP_W     = 7;
    localparam int PHASE_W    = 16;
    localparam int LEVEL_W    = 8;
    localparam int DUR_W      = 16;
    localparam int IDX_LSB    = 3;
    localparam logic [PHASE_W-1:0] IDX_ROUND = 16'd4;

    localparam logic [STEP_W-1:0] LOW_STEP_TABLE [5] = '{7'd0, 7'd46, 7'd50, 7'd56, 7'd61};
    localparam logic [STEP_W-1:0] HIGH_STEP_TABLE [5] = '{7'd0, 7'd79, 7'd87, 7'd96, 7'd107};

    localparam logic [SINE_W-1:0] SINE_TABLE [SINE_DEPTH] = '{
        7'd64, 7'd67, 7'd70, 7'd73, 7'd76, 7'd79, 7'd82, 7'd85,
        7'd88, 7'd91, 7'd94, 7'd96, 7'd99, 7'd102, 7'd104, 7'd106,
        7'd109, 7'd111, 7'd113, 7'd115, 7'd117, 7'd118, 7'd120, 7'd121,
        7'd123, 7'd124, 7'd125, 7'd126, 7'd126, 7'd127, 7'd127, 7'd127,
        7'd127, 7'd127, 7'd127, 7'd127, 7'd126, 7'd126, 7'd125, 7'd124,
        7'd123, 7'd121, 7'd120, 7'd118, 7'd117, 7'd115, 7'd113, 7'd111,
        7'd109, 7'd106, 7'd104, 7'd102, 7'd99, 7'd96, 7'd94, 7'd91,
        7'd88, 7'd85, 7'd82, 7'd79, 7'd76, 7'd73, 7'd70, 7'd67,
        7'd64, 7'd60, 7'd57, 7'd54, 7'd51, 7'd48, 7'd45, 7'd42,
        7'd39, 7'd36, 7'd33, 7'd31, 7'd28, 7'd25, 7'd23, 7'd21,
        7'd18, 7'd16, 7'd14, 7'd12, 7'd10, 7'd9, 7'd7, 7'd6,
        7'd4, 7'd3, 7'd2, 7'd1, 7'd1, 7'd0, 7'd0, 7'd0,
        7'd0, 7'd0, 7'd0, 7'd0, 7'd1, 7'd1, 7'd2, 7'd3,
        7'd4, 7'd6, 7'd7, 7'd9, 7'd10, 7'd12, 7'd14, 7'd16,
        7'd18, 7'd21, 7'd23, 7'd25, 7'd28, 7'd31, 7'd33, 7'd36,
        7'd39, 7'd42, 7'd45, 7'd48, 7'd51, 7'd54, 7'd57, 7'd60
    };

    typedef struct packed {
        logic       valid;
        logic [2:0] low_sel;
        logic [2:0] high_sel;
    } key_t;

    // Pipeline control between the phase stage and the mix stage.
    typedef struct packed {
        logic mix;
        logic stop;
        logic active;
        logic accepted;
    } stage_ctrl_t;

    function automatic key_t key_decode(input logic [7:0] ch);
        key_t k;
        k = '{valid: 1'b1, low_sel: 3'd0, high_sel: 3'd0};
        unique case (ch) inside
            8'h31:        begin k.low_sel = 3'd1; k.high_sel = 3'd1; end
            8'h32:        begin k.low_sel = 3'd1; k.high_sel = 3'd2; end
            8'h33:        begin k.low_sel = 3'd1; k.high_sel = 3'd3; end
            8'h41, 8'h61: begin k.low_sel = 3'd1; k.high_sel = 3'd4; end
            8'h34:        begin k.low_sel = 3'd2; k.high_sel = 3'd1; end
            8'h35:        begin k.low_sel = 3'd2; k.high_sel = 3'd2; end
            8'h36:        begin k.low_sel = 3'd2; k.high_sel = 3'd3; end
            8'h42, 8'h62: begin k.low_sel = 3'd2; k.high_sel = 3'd4; end
            8'h37:        begin k.low_sel = 3'd3; k.high_sel = 3'd1; end
            8'h38:        begin k.low_sel = 3'd3; k.high_sel = 3'd2; end
            8'h39:        begin k.low_sel = 3'd3; k.high_sel = 3'd3; end
            8'h43, 8'h63: begin k.low_sel = 3'd3; k.high_sel = 3'd4; end
            8'h2A:        begin k.low_sel = 3'd4; k.high_sel = 3'd1; end
            8'h30:        begin k.low_sel = 3'd4; k.high_sel = 3'd2; end
            8'h23:        begin k.low_sel = 3'd4; k.high_sel = 3'd3; end
            8'h44, 8'h64: begin k.low_sel = 3'd4; k.high_sel = 3'd4; end
            default:      k.valid = 1'b0;
        endcase
        return k;
    endfunction

endpackage

// ===== design/dts_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
module dts_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 128,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== design/dtmf_tone_synthesizer.sv =====
// DTMF tone synthesizer top level: phase stage, sine RAM lookup, mix stage, output register.
// Depends on dts_pkg and dts_ram.
//
// Takes one request per clock while in_ready is high, and returns one result per request;
// the request is registered in the phase stage and the result in the output register, which
// holds it while out_ready is low. The phase stage, which sets the rate, updates both
// accumulators, the tone timer and the key steps together and issues the two sine lookups to
// the RAMs; the level is then mixed from the registered RAM data. After reset the two sine
// RAMs are loaded from the package table, one entry per cycle: in_ready stays low until the last entry is written.
module dtmf_tone_synthesizer
    import dts_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [1:0]         action,
    input  logic [7:0]         char_code,
    input  logic [DUR_W-1:0]   duration_ms,
    output logic               out_valid,
    input  logic               out_ready,
    output logic [LEVEL_W-1:0] pwm_level,
    output logic               tone_active,
    output logic               accepted
);

    logic [SINE_AW-1:0] init_addr_reg;
    logic               init_done_reg;

    logic [PHASE_W-1:0] low_phase_reg, low_phase_next;
    logic [PHASE_W-1:0] high_phase_reg, high_phase_next;
    logic [STEP_W-1:0]  low_step_reg, low_step_next;
    logic [STEP_W-1:0]  high_step_reg, high_step_next;
    logic [DUR_W-1:0]   remaining_reg, remaining_next;
    logic               running_reg, running_next;

    logic               p1_valid_reg;
    stage_ctrl_t        p1_ctrl_reg, p1_ctrl_next;

    logic               out_valid_reg;
    logic               out_active_reg;
    logic               out_accepted_reg;
    logic [LEVEL_W-1:0] level_reg, level_next;

    logic               take;
    logic               en1;
    logic               en2;
    key_t               key;
    logic [PHASE_W-1:0] low_round;
    logic [PHASE_W-1:0] high_round;
    logic [SINE_W-1:0]  low_sine;
    logic [SINE_W-1:0]  high_sine;
    logic [SINE_W-1:0]  low_scaled;

    assign en2      = !out_valid_reg || out_ready;
    assign en1      = !p1_valid_reg || en2;
    assign in_ready = init_done_reg && en1;
    assign take     = in_valid && in_ready;
    assign key      = key_decode(char_code);

    // sine table load
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_addr_reg <= '0;
            init_done_reg <= 1'b0;
        end
        else if (!init_done_reg)
        begin
            init_addr_reg <= init_addr_reg + 1'b1;
            if (init_addr_reg == SINE_AW'(SINE_DEPTH - 1))
            begin
                init_done_reg <= 1'b1;
            end
        end
    end

    // phase stage
    always_comb
    begin
        low_phase_next  = low_phase_reg;
        high_phase_next = high_phase_reg;
        low_step_next   = low_step_reg;
        high_step_next  = high_step_reg;
        remaining_next  = remaining_reg;
        running_next    = running_reg;
        p1_ctrl_next    = '{mix: 1'b0, stop: 1'b0, active: 1'b0, accepted: 1'b0};
        unique case (action)
            ACT_START:
            begin
                if (!key.valid)
                begin
                    running_next      = 1'b0;
                    remaining_next    = '0;
                    p1_ctrl_next.stop = 1'b1;
                end
                else
                begin
                    p1_ctrl_next.accepted = 1'b1;
                    low_step_next  = LOW_STEP_TABLE[key.low_sel];
                    high_step_next = HIGH_STEP_TABLE[key.high_sel];
                    if (duration_ms == '0)
                    begin
                        running_next      = 1'b0;
                        remaining_next    = '0;
                        p1_ctrl_next.stop = 1'b1;
                    end
                    else
                    begin
                        remaining_next = duration_ms;
                        running_next   = 1'b1;
                    end
                end
            end
            ACT_SAMPLE:
            begin
                if (running_reg)
                begin
                    low_phase_next   = low_phase_reg + PHASE_W'(low_step_reg);
                    high_phase_next  = high_phase_reg + PHASE_W'(high_step_reg);
                    p1_ctrl_next.mix = 1'b1;
                end
            end
            ACT_MS:
            begin
                if (running_reg)
                begin
                    if (remaining_reg <= DUR_W'(1))
                    begin
                        running_next      = 1'b0;
                        remaining_next    = '0;
                        p1_ctrl_next.stop = 1'b1;
                    end
                    else
                    begin
                        remaining_next = remaining_reg - 1'b1;
                    end
                end
            end
            default:
            begin
            end
        endcase
        p1_ctrl_next.active = running_next;
    end

    assign low_round  = low_phase_next + IDX_ROUND;
    assign high_round = high_phase_next + IDX_ROUND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            low_phase_reg  <= '0;
            high_phase_reg <= '0;
            low_step_reg   <= '0;
            high_step_reg  <= '0;
            remaining_reg  <= '0;
            running_reg    <= 1'b0;
            p1_valid_reg   <= 1'b0;
            p1_ctrl_reg    <= '0;
        end
        else
        begin
            if (take)
            begin
                low_phase_reg  <= low_phase_next;
                high_phase_reg <= high_phase_next;
                low_step_reg   <= low_step_next;
                high_step_reg  <= high_step_next;
                remaining_reg  <= remaining_next;
                running_reg    <= running_next;
                p1_ctrl_reg    <= p1_ctrl_next;
            end
            if (en1)
            begin
                p1_valid_reg <= take;
            end
        end
    end

    dts_ram #(
        .WIDTH (SINE_W),
        .DEPTH (SINE_DEPTH)
    ) u_low_ram (
        .clk   (clk),
        .we    (!init_done_reg),
        .waddr (init_addr_reg),
        .wdata (SINE_TABLE[init_addr_reg]),
        .re    (en1),
        .raddr (low_round[IDX_LSB +: SINE_AW]),
        .rdata (low_sine)
    );

    dts_ram #(
        .WIDTH (SINE_W),
        .DEPTH (SINE_DEPTH)
    ) u_high_ram (
        .clk   (clk),
        .we    (!init_done_reg),
        .waddr (init_addr_reg),
        .wdata (SINE_TABLE[init_addr_reg]),
        .re    (en1),
        .raddr (high_round[IDX_LSB +: SINE_AW]),
        .rdata (high_sine)
    );

    // mix stage: high + 3/4 low
    assign low_scaled = low_sine - (low_sine >> 2);

    always_comb
    begin
        level_next = level_reg;
        if (p1_ctrl_reg.mix)
        begin
            level_next = LEVEL_W'(high_sine) + LEVEL_W'(low_scaled);
        end
        else if (p1_ctrl_reg.stop)
        begin
            level_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg    <= 1'b0;
            out_active_reg   <= 1'b0;
            out_accepted_reg <= 1'b0;
            level_reg        <= '0;
        end
        else if (en2)
        begin
            out_valid_reg <= p1_valid_reg;
            if (p1_valid_reg)
            begin
                level_reg        <= level_next;
                out_active_reg   <= p1_ctrl_reg.active;
                out_accepted_reg <= p1_ctrl_reg.accepted;
            end
        end
    end

    assign out_valid   = out_valid_reg;
    assign pwm_level   = level_reg;
    assign tone_active = out_active_reg;
    assign accepted    = out_accepted_reg;

endmodule

// ===== design/dts_checker.sv =====
// Port-level checker for the DTMF tone synthesizer, bound to the top level.
// Depends on dts_pkg and dtmf_tone_synthesizer_assert.svh.
`include "dtmf_tone_synthesizer_assert.svh"

module dts_checker
    import dts_pkg::*;
(
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_ready,
    input logic [1:0]         action,
    input logic [7:0]         char_code,
    input logic [DUR_W-1:0]   duration_ms,
    input logic               out_valid,
    input logic               out_ready,
    input logic [LEVEL_W-1:0] pwm_level,
    input logic               tone_active,
    input logic               accepted
);

    logic                     in_stall;
    logic                     out_stall;
    logic [DUR_W+9:0]         req_bits;
    logic [LEVEL_W+1:0]       result_bits;

    assign in_stall    = in_valid && !in_ready;
    assign out_stall   = out_valid && !out_ready;
    assign req_bits    = {action, char_code, duration_ms};
    assign result_bits = {pwm_level, tone_active, accepted};

    `DTS_ASSERT_NOW(a_idle_silent, out_valid && !tone_active, pwm_level == '0, "level not zero")
    `DTS_ASSERT_NOW(a_level_range, out_valid, pwm_level <= LEVEL_W'(223), "level out of range")
    `DTS_ASSERT_NEXT(a_out_hold, out_stall, out_valid && $stable(result_bits), "result changed")
    `DTS_ASSERT_NEXT(a_req_hold, in_stall, in_valid && $stable(req_bits), "request changed")

endmodule

bind dtmf_tone_synthesizer dts_checker u_dts_checker (.*);
